>>> hw/rtl/bfd_session_liveness_table_assert.svh
// Assertion macros for the BFD session liveness table checker
`ifndef BFD_SESSION_LIVENESS_TABLE_ASSERT_SVH
`define BFD_SESSION_LIVENESS_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while in reset
`define BFDSLT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet while in reset
`define BFDSLT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/bfdslt_pkg.sv
// Shared constants, types and helpers of the BFD session liveness table
`timescale 1ns / 1ps
package bfdslt_pkg;

	localparam int PORT_SLOTS    = 32;
	localparam int BFD_PKT_BYTES = 24;

	localparam int PORT_W  = 6;
	localparam int LEN_W   = 16;
	localparam int TIME_W  = 32;
	localparam int ACT_W   = 6;
	localparam int CFG_W   = 32;
	localparam int CFG_IW  = 2;
	localparam int IDX_W   = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
	localparam int LIVE_W  = $clog2(PORT_SLOTS + 1);
	localparam int EXT_W   = PORT_W + 1;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
	localparam int RESQ_DEPTH = 2;
	localparam int RESQ_AW    = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
	localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

	localparam logic [CFG_IW-1:0] CFG_ACTIVE_PORTS = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_TIMEOUT_US   = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_LOCAL_DISC   = 2'd2;

	localparam logic [ACT_W-1:0]  ACTIVE_RST  = 6'd1;
	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd1000;

	localparam logic OP_PKT    = 1'b0;
	localparam logic OP_TICK   = 1'b1;
	localparam logic KIND_PKT  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_ADMINDOWN = 2'd0,
		ST_DOWN      = 2'd1,
		ST_INIT      = 2'd2,
		ST_UP        = 2'd3
	} state_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_SHORT    = 2'd1,
		STAT_BAD_PORT = 2'd2
	} status_t;

	typedef struct packed {
		logic              op;
		logic [PORT_W-1:0] port;
		status_t           status;
		logic              in_range;
		logic [TIME_W-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic              kind;
		logic [PORT_W-1:0] report_port;
		status_t           status;
		state_t            remote_now;
		logic              send_echo;
		logic              remote_down;
		logic              last;
	} res_t;

	// active port count, saturated to the table size
	function automatic logic [LIVE_W-1:0] live_count(input logic [ACT_W-1:0] act);
		logic [ACT_W:0] ext;
		ext = {1'b0, act};
		if (ext > (ACT_W + 1)'(PORT_SLOTS))
			return LIVE_W'(PORT_SLOTS);
		else
			return LIVE_W'(act);
	endfunction

endpackage

>>> hw/rtl/bfd_session_liveness_table.sv
// Top level of the BFD session liveness table
//
//  channel   direction  handshake        fields
//  input     in         push / full      op port udp_length peer_discriminator
//                                        version_diag now_us
//  result    out        empty / pop      kind report_port status remote_now
//                                        send_echo remote_down last
//  config    in         cfg_wr_en        cfg_index cfg_data
//
//  A packet item needs no table walk: the remote state lives in flops and
//  the receive time RAM is only written. A tick walks the active ports
//  (capped at the table size), one port per cycle while the result queue is not
//  full, bounded by the single read port of the receive time RAM.
//  Two-entry queues on both sides let front and back stall independently.
//  Reset is asynchronous; tables come up valid at once, no clearing pass.
`timescale 1ns / 1ps
module bfd_session_liveness_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          op,
	input  logic [bfdslt_pkg::PORT_W-1:0] port,
	input  logic [bfdslt_pkg::LEN_W-1:0]  udp_length,
	input  logic [31:0]                   peer_discriminator,
	input  logic [7:0]                    version_diag,
	input  logic [bfdslt_pkg::TIME_W-1:0] now_us,
	output logic                          empty,
	input  logic                          pop,
	output logic                          kind,
	output logic [bfdslt_pkg::PORT_W-1:0] report_port,
	output logic [1:0]                    status,
	output logic [1:0]                    remote_now,
	output logic                          send_echo,
	output logic                          remote_down,
	output logic                          last,
	input  logic                          cfg_wr_en,
	input  logic [bfdslt_pkg::CFG_IW-1:0] cfg_index,
	input  logic [bfdslt_pkg::CFG_W-1:0]  cfg_data
);
	import bfdslt_pkg::*;

	logic [ACT_W-1:0]  active_q;
	logic [TIME_W-1:0] timeout_q;
	logic [LIVE_W-1:0] live;
	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_pop;
	logic              res_push;
	res_t              res;
	logic              res_full;
	res_t              head;

	assign live = live_count(active_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= ACTIVE_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ACTIVE_PORTS: active_q  <= cfg_data[ACT_W-1:0];
				CFG_TIMEOUT_US:   timeout_q <= cfg_data[TIME_W-1:0];
				CFG_LOCAL_DISC:   ;
				default:          ;
			endcase
		end
	end

	bfdslt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.port       (port),
		.udp_length (udp_length),
		.now_us     (now_us),
		.live       (live),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	bfdslt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.live       (live),
		.timeout_us (timeout_q),
		.res_push   (res_push),
		.res        (res),
		.res_full   (res_full)
	);

	bfdslt_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign kind        = head.kind;
	assign report_port = head.report_port;
	assign status      = head.status;
	assign remote_now  = head.remote_now;
	assign send_echo   = head.send_echo;
	assign remote_down = head.remote_down;
	assign last        = head.last;

endmodule

>>> hw/rtl/bfdslt_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module bfdslt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

>>> hw/rtl/bfdslt_front.sv
// Front end: input checks, packet classification and the command queue
`timescale 1ns / 1ps
module bfdslt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         op,
	input  logic [bfdslt_pkg::PORT_W-1:0] port,
	input  logic [bfdslt_pkg::LEN_W-1:0]  udp_length,
	input  logic [bfdslt_pkg::TIME_W-1:0] now_us,
	input  logic [bfdslt_pkg::LIVE_W-1:0] live,
	output logic                         cmd_valid,
	output bfdslt_pkg::cmd_t             cmd,
	input  logic                         cmd_pop
);
	import bfdslt_pkg::*;

	cmd_t               ent_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] cnt_q;
	cmd_t               in_cmd;
	logic               do_push;
	logic               do_pop;

	always_comb begin
		in_cmd          = '0;
		in_cmd.op       = op;
		in_cmd.port     = port;
		in_cmd.now      = now_us;
		in_cmd.in_range = ({1'b0, port} < EXT_W'(live));
		if (udp_length < LEN_W'(BFD_PKT_BYTES))
			in_cmd.status = STAT_SHORT;
		else if (!in_cmd.in_range)
			in_cmd.status = STAT_BAD_PORT;
		else
			in_cmd.status = STAT_OK;
	end

	assign full      = (cnt_q == CMDQ_CW'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = ent_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= in_cmd;
	end

endmodule

>>> hw/rtl/bfdslt_back.sv
// Back end: session table updates, tick walk and result generation
`timescale 1ns / 1ps
module bfdslt_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  bfdslt_pkg::cmd_t              cmd,
	output logic                          cmd_pop,
	input  logic [bfdslt_pkg::LIVE_W-1:0] live,
	input  logic [bfdslt_pkg::TIME_W-1:0] timeout_us,
	output logic                          res_push,
	output bfdslt_pkg::res_t              res,
	input  logic                          res_full
);
	import bfdslt_pkg::*;

	typedef enum logic {
		B_IDLE,
		B_WALK
	} bstate_t;

	bstate_t               state_q;
	state_t                remote_q [PORT_SLOTS];
	state_t                local_q  [PORT_SLOTS];
	logic [PORT_SLOTS-1:0] rx_vld_q;
	logic                  rd_vld_q;
	logic [IDX_W-1:0]      idx_q;
	logic [TIME_W-1:0]     now_q;

	logic                  ram_wr_en;
	logic                  ram_rd_en;
	logic [IDX_W-1:0]      ram_rd_addr;
	logic [TIME_W-1:0]     ram_rd_data;

	logic [IDX_W-1:0]      pkt_idx;
	logic [IDX_W-1:0]      idx_nxt;
	logic                  is_pkt;
	logic                  pkt_ok;
	logic [TIME_W-1:0]     last_rx;
	logic [TIME_W-1:0]     elapsed;
	state_t                cur_rem;
	state_t                cur_loc;
	logic                  timed_out;
	logic                  echo;
	logic                  walk_last;

	// last receive time per port; entries never written are taken as zero through rx_vld_q
	bfdslt_ram #(
		.WIDTH (TIME_W),
		.DEPTH (PORT_SLOTS)
	) u_rx_time (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (pkt_idx),
		.wr_data (cmd.now),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign pkt_idx   = cmd.port[IDX_W-1:0];
	assign idx_nxt   = idx_q + 1'b1;
	assign is_pkt    = (cmd.op == OP_PKT);
	assign pkt_ok    = (cmd.status == STAT_OK);
	assign last_rx   = rd_vld_q ? ram_rd_data : '0;
	assign elapsed   = now_q - last_rx;
	assign cur_rem   = remote_q[idx_q];
	assign cur_loc   = local_q[idx_q];
	assign timed_out = (cur_rem == ST_UP) && (elapsed > timeout_us);
	assign echo      = !(cur_loc == ST_DOWN || cur_loc == ST_ADMINDOWN);
	assign walk_last = ((LIVE_W'(idx_q) + LIVE_W'(1)) == live);

	always_comb begin
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		res         = '0;
		ram_wr_en   = 1'b0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					if (is_pkt) begin
						if (!res_full) begin
							cmd_pop         = 1'b1;
							res_push        = 1'b1;
							res.kind        = KIND_PKT;
							res.report_port = cmd.port;
							res.status      = cmd.status;
							res.last        = 1'b1;
							ram_wr_en       = pkt_ok;
							if (!cmd.in_range)
								res.remote_now = ST_ADMINDOWN;
							else if (pkt_ok)
								res.remote_now = ST_UP;
							else
								res.remote_now = remote_q[pkt_idx];
						end
					end else begin
						cmd_pop   = 1'b1;
						ram_rd_en = (live != '0);
					end
				end
			end
			B_WALK: begin
				if (!res_full) begin
					res_push        = 1'b1;
					res.kind        = KIND_TICK;
					res.report_port = PORT_W'(idx_q);
					res.status      = STAT_OK;
					res.remote_now  = timed_out ? ST_DOWN : cur_rem;
					res.send_echo   = echo;
					res.remote_down = timed_out;
					res.last        = walk_last;
					ram_rd_en       = !walk_last;
					ram_rd_addr     = idx_nxt;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			rx_vld_q <= '0;
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
			for (int i = 0; i < PORT_SLOTS; i++) begin
				remote_q[i] <= ST_INIT;
				local_q[i]  <= ST_INIT;
			end
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid && is_pkt && !res_full && pkt_ok) begin
						remote_q[pkt_idx] <= ST_UP;
						rx_vld_q[pkt_idx] <= 1'b1;
					end
					if (cmd_valid && !is_pkt && live != '0) begin
						state_q  <= B_WALK;
						idx_q    <= '0;
						rd_vld_q <= rx_vld_q[0];
					end
				end
				B_WALK: begin
					if (!res_full) begin
						if (cur_loc == ST_INIT)
							local_q[idx_q] <= ST_UP;
						if (timed_out)
							remote_q[idx_q] <= ST_DOWN;
						if (walk_last) begin
							state_q <= B_IDLE;
						end else begin
							idx_q    <= idx_nxt;
							rd_vld_q <= rx_vld_q[idx_nxt];
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && cmd_valid && !is_pkt)
			now_q <= cmd.now;
	end

endmodule

>>> hw/rtl/bfdslt_resq.sv
// Result queue between the back end and the result ports
`timescale 1ns / 1ps
module bfdslt_resq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_push,
	input  bfdslt_pkg::res_t res,
	output logic             res_full,
	output logic             empty,
	input  logic             pop,
	output bfdslt_pkg::res_t head
);
	import bfdslt_pkg::*;

	res_t               ent_q [RESQ_DEPTH];
	logic [RESQ_AW-1:0] wr_ptr_q;
	logic [RESQ_AW-1:0] rd_ptr_q;
	logic [RESQ_CW-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign res_full = (cnt_q == RESQ_CW'(RESQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign head     = ent_q[rd_ptr_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= res;
	end

endmodule

>>> hw/rtl/bfd_session_liveness_table_chk.sv
// Port-level checker for the BFD session liveness table, with its bind
`timescale 1ns / 1ps
`include "bfd_session_liveness_table_assert.svh"
module bfd_session_liveness_table_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic                          empty,
	input logic                          pop,
	input logic                          kind,
	input logic [bfdslt_pkg::PORT_W-1:0] report_port,
	input logic [1:0]                    status,
	input logic [1:0]                    remote_now,
	input logic                          send_echo,
	input logic                          remote_down,
	input logic                          last
);
	import bfdslt_pkg::*;

	`BFDSLT_ASSERT_NOW(a_tick_status_ok, !empty && kind == KIND_TICK, status == STAT_OK, "tick report with nonzero status")
	`BFDSLT_ASSERT_NOW(a_pkt_single, !empty && kind == KIND_PKT, last && !send_echo && !remote_down, "packet result not single or carries tick flags")
	`BFDSLT_ASSERT_NOW(a_down_state, !empty && remote_down, remote_now == ST_DOWN, "timeout flagged but remote not Down")
	`BFDSLT_ASSERT_NXT(a_head_held, !empty && !pop, !empty, "waiting result vanished without pop")

endmodule

bind bfd_session_liveness_table bfd_session_liveness_table_chk u_chk (.*);

>>> dv/testbench.sv
// Testbench for the BFD session liveness table: directed and random items checked per field
`timescale 1ns / 1ps
module testbench;
	import bfdslt_pkg::*;

	localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 2 * PORT_SLOTS + 16;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	logic                op;
	logic [PORT_W-1:0]   port;
	logic [LEN_W-1:0]    udp_length;
	logic [31:0]         peer_discriminator;
	logic [7:0]          version_diag;
	logic [TIME_W-1:0]   now_us;
	logic                empty;
	logic                pop;
	logic                kind;
	logic [PORT_W-1:0]   report_port;
	logic [1:0]          status;
	logic [1:0]          remote_now;
	logic                send_echo;
	logic                remote_down;
	logic                last;
	logic                cfg_wr_en;
	logic [CFG_IW-1:0]   cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	bfd_session_liveness_table dut (.*);

	// session predictor state
	logic [ACT_W-1:0]  act_ports  = ACTIVE_RST;
	logic [TIME_W-1:0] timeout    = TIMEOUT_RST;
	logic [31:0]       local_disc = '0;
	state_t            local_st [PORT_SLOTS] = '{default: ST_INIT};
	state_t            remote_st [PORT_SLOTS] = '{default: ST_INIT};
	logic [31:0]       peer_disc [PORT_SLOTS] = '{default: '0};
	logic [7:0]        remote_diag [PORT_SLOTS] = '{default: '0};
	logic [TIME_W-1:0] rx_time [PORT_SLOTS] = '{default: '0};

	res_t reports_due [$];
	int   errors = 0;
	int   quiet_cycles = 0;
	int   in_gap_max = 0;
	int   out_gap_max = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void apply_reg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] data);
		case (idx)
		CFG_ACTIVE_PORTS: act_ports = data[ACT_W-1:0];
		CFG_TIMEOUT_US: timeout = data;
		CFG_LOCAL_DISC: begin
			local_disc = data;
			for (int i = 0; i < PORT_SLOTS; i++)
				peer_disc[i] = data;
		end
		default: ;
		endcase
	endfunction

	function automatic void predict_reports(input logic op_i, input logic [PORT_W-1:0] port_i,
			input logic [LEN_W-1:0] len_i, input logic [31:0] disc_i, input logic [7:0] diag_i,
			input logic [TIME_W-1:0] now_i);
		res_t r;
		int n;
		logic [TIME_W-1:0] elapsed;
		n = (act_ports > PORT_SLOTS) ? PORT_SLOTS : int'(act_ports);
		if (op_i == OP_PKT) begin
			r = '0;
			r.kind = KIND_PKT;
			r.report_port = port_i;
			r.remote_now = ST_ADMINDOWN;
			r.last = 1'b1;
			if (len_i < BFD_PKT_BYTES)
				r.status = STAT_SHORT;
			else if (port_i >= n)
				r.status = STAT_BAD_PORT;
			else begin
				r.status = STAT_OK;
				if (remote_st[port_i] != ST_UP) begin
					remote_st[port_i] = ST_UP;
					peer_disc[port_i] = disc_i;
				end
				remote_diag[port_i] = diag_i;
				rx_time[port_i] = now_i;
			end
			if (port_i < n)
				r.remote_now = remote_st[port_i];
			reports_due.push_back(r);
		end else begin
			for (int i = 0; i < n; i++) begin
				r = '0;
				r.kind = KIND_TICK;
				r.report_port = PORT_W'(i);
				r.status = STAT_OK;
				r.send_echo = 1'b1;
				if (local_st[i] == ST_INIT)
					local_st[i] = ST_UP;
				else if (local_st[i] == ST_DOWN || local_st[i] == ST_ADMINDOWN)
					r.send_echo = 1'b0;
				if (remote_st[i] == ST_UP) begin
					elapsed = now_i - rx_time[i];
					if (elapsed > timeout) begin
						remote_st[i] = ST_DOWN;
						r.remote_down = 1'b1;
					end
				end
				r.remote_now = remote_st[i];
				r.last = (i == n - 1);
				reports_due.push_back(r);
			end
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	function automatic void check_report();
		res_t want;
		if (reports_due.size() == 0) begin
			errors++;
			$display("%0t unexpected report: expected none actual port %0d kind %0d",
				$time, report_port, kind);
			return;
		end
		want = reports_due.pop_front();
		compare_field("kind", 32'(want.kind), 32'(kind));
		compare_field("report_port", 32'(want.report_port), 32'(report_port));
		compare_field("status", 32'(want.status), 32'(status));
		compare_field("remote_now", 32'(want.remote_now), 32'(remote_now));
		compare_field("send_echo", 32'(want.send_echo), 32'(send_echo));
		compare_field("remote_down", 32'(want.remote_down), 32'(remote_down));
		compare_field("last", 32'(want.last), 32'(last));
	endfunction

	always @(posedge clk) begin : monitor
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_wr_en) begin
				apply_reg_write(cfg_index, cfg_data);
				moved = 1'b1;
			end
			if (push && !full) begin
				predict_reports(op, port, udp_length, peer_discriminator, version_diag, now_us);
				moved = 1'b1;
			end
			if (pop && !empty) begin
				check_report();
				moved = 1'b1;
			end
		end
		quiet_cycles <= moved ? 0 : quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("testbench: errors");
		$finish;
	end

	initial begin : result_drain
		int gap;
		int taken;
		taken = 0;
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (taken % 25 == 0)
				out_gap_max = $urandom_range(0, 1) ? 9 : 0;
			gap = $urandom_range(0, out_gap_max);
			if (gap != 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop = 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			taken++;
		end
	end

	task automatic send_item(input logic op_i, input logic [PORT_W-1:0] port_i,
			input logic [LEN_W-1:0] len_i, input logic [31:0] disc_i, input logic [7:0] diag_i,
			input logic [TIME_W-1:0] now_i);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op = op_i;
		port = port_i;
		udp_length = len_i;
		peer_discriminator = disc_i;
		version_diag = diag_i;
		now_us = now_i;
		push = 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_tick(input logic [TIME_W-1:0] now_i);
		send_item(OP_TICK, PORT_W'($urandom_range(0, 63)), LEN_W'($urandom_range(0, 16'hffff)),
			$urandom, 8'($urandom_range(0, 255)), now_i);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// a tick over zero ports leaves no report, so settle after the queue drains
	task automatic wait_idle();
		@(negedge clk);
		push = 1'b0;
		while (reports_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic test_defaults();
		in_gap_max = 9;
		send_tick(32'd0);
		send_item(OP_PKT, 6'd0, 16'd24, 32'hffff_ffff, 8'hff, 32'd200);
		send_item(OP_PKT, 6'd0, 16'hffff, 32'h0, 8'h00, 32'd200);
		send_item(OP_PKT, 6'd63, 16'd23, $urandom, 8'h5a, 32'd300);
		send_item(OP_PKT, 6'd1, 16'd0, $urandom, 8'ha5, 32'd300);
		send_item(OP_PKT, 6'd1, 16'd24, $urandom, 8'h11, 32'd300);
		send_tick(32'd1200);
		send_tick(32'd1201);
		send_tick(32'd1202);
		send_item(OP_PKT, 6'd0, 16'd1000, 32'h1234_5678, 8'h20, 32'hffff_fff0);
		send_tick(32'h0000_0300);
	endtask

	task automatic test_register_extremes();
		in_gap_max = 0;
		wait_idle();
		write_reg(CFG_ACTIVE_PORTS, 32'd32);
		write_reg(CFG_TIMEOUT_US, 32'd0);
		write_reg(CFG_LOCAL_DISC, 32'hffff_ffff);
		write_reg(CFG_UNUSED, 32'hdead_beef);
		send_item(OP_PKT, 6'd31, 16'd24, 32'h0bad_cafe, 8'h3c, 32'h10);
		send_item(OP_PKT, 6'd32, 16'd24, $urandom, 8'h3c, 32'h10);
		send_tick(32'h10);
		send_tick(32'h11);
		wait_idle();
		write_reg(CFG_ACTIVE_PORTS, 32'd0);
		send_tick(32'h20);
		send_item(OP_PKT, 6'd0, 16'd24, $urandom, 8'h01, 32'h20);
		wait_idle();
		write_reg(CFG_ACTIVE_PORTS, 32'd63);
		write_reg(CFG_TIMEOUT_US, 32'hffff_ffff);
		write_reg(CFG_LOCAL_DISC, 32'h0);
		send_item(OP_PKT, 6'd5, 16'd24, $urandom, 8'h02, 32'h0);
		send_tick(32'hffff_ffff);
	endtask

	task automatic test_random_traffic();
		logic [ACT_W-1:0]  act;
		int                live;
		logic [TIME_W-1:0] tmo;
		logic [TIME_W-1:0] clock_us;
		logic              op_r;
		logic [PORT_W-1:0] port_r;
		logic [LEN_W-1:0]  len_r;
		logic [TIME_W-1:0] now_r;
		bit                noise;
		clock_us = $urandom;
		for (int phase = 0; phase < 8; phase++) begin
			act = (phase == 2) ? 6'd32 : (phase == 5) ? 6'd63 : ACT_W'($urandom_range(1, 8));
			live = (act > PORT_SLOTS) ? PORT_SLOTS : int'(act);
			tmo = $urandom_range(50, 2000);
			wait_idle();
			write_reg(CFG_ACTIVE_PORTS, CFG_W'(act));
			write_reg(CFG_TIMEOUT_US, tmo);
			if (phase % 2 == 1)
				write_reg(CFG_LOCAL_DISC, $urandom);
			for (int k = 0; k < 58; k++) begin
				if (k % 20 == 0)
					in_gap_max = $urandom_range(0, 1) ? 9 : 0;
				noise = ($urandom_range(0, 9) == 0);
				op_r = ($urandom_range(0, 99) < 12) ? OP_TICK : OP_PKT;
				clock_us += $urandom_range(0, tmo / 2);
				if (noise) begin
					port_r = PORT_W'($urandom_range(0, 63));
					len_r = LEN_W'($urandom_range(0, 16'hffff));
					now_r = $urandom;
				end else begin
					port_r = PORT_W'($urandom_range(0, live - 1));
					len_r = LEN_W'($urandom_range(BFD_PKT_BYTES, 16'hffff));
					now_r = clock_us;
				end
				send_item(op_r, port_r, len_r, $urandom, 8'($urandom_range(0, 255)), now_r);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		op = OP_PKT;
		port = '0;
		udp_length = '0;
		peer_discriminator = '0;
		version_diag = '0;
		now_us = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_ACTIVE_PORTS;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_defaults();
		test_register_extremes();
		test_random_traffic();
		wait_idle();
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
